FILE: hdl/fsid_pkg.sv
// Shared constants, register indexes and helper functions of the image decimator.
`timescale 1ns / 1ps

package fsid_pkg;

    localparam int DIM_BITS   = 12;                      // counter width, max 4096 per axis
    localparam int FRAC_BITS  = 12;                      // fraction bits of step and offset
    localparam int POS_W      = DIM_BITS + FRAC_BITS + 1;
    localparam int DIMCFG_W   = 13;
    localparam int STEP_W     = 16;
    localparam int OFS_W      = 24;
    localparam int GAIN_W     = 2 * STEP_W;
    localparam int PIX_W      = 16;
    localparam int OUT_W      = 32;
    localparam int OUT_FRAC   = 8;
    localparam int GAIN_SHIFT = 2 * FRAC_BITS - OUT_FRAC;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE    = 3'd4;

    localparam logic [DIMCFG_W-1:0] DIM_MAX  = DIMCFG_W'(1 << DIM_BITS);
    localparam logic [STEP_W-1:0]   STEP_ONE = STEP_W'(1 << FRAC_BITS);

    // Reset values of the derived register copies.
    localparam logic [DIMCFG_W-1:0] DIM_RESET  = DIMCFG_W'(1);
    localparam logic [STEP_W-1:0]   STEP_RESET = STEP_W'(8192);
    localparam logic [GAIN_W-1:0]   GAIN_RESET = GAIN_W'(64'd8192 * 64'd8192);

    // Clamp a dimension into 1 .. 2^DIM_BITS.
    function automatic logic [DIMCFG_W-1:0] eff_dim(input logic [DIMCFG_W-1:0] d);
        logic [DIMCFG_W-1:0] r;
        if (d == '0)
            r = DIMCFG_W'(1);
        else if (d > DIM_MAX)
            r = DIM_MAX;
        else
            r = d;
        return r;
    endfunction

    // Steps below one are taken as one.
    function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
        return (s < STEP_ONE) ? STEP_ONE : s;
    endfunction

endpackage

FILE: hdl/fsid_scale.sv
// Gain stage: pixel times step squared (or times one), floor shift and saturation to Q24.8.
`timescale 1ns / 1ps

module fsid_scale (
    input  logic signed [fsid_pkg::PIX_W-1:0]  pixel,
    input  logic        [fsid_pkg::GAIN_W-1:0] gain,
    input  logic                               normalize,
    output logic signed [fsid_pkg::OUT_W-1:0]  scaled
);
    import fsid_pkg::*;

    localparam int PROD_W = PIX_W + GAIN_W + 1;
    localparam int SHR_W  = PROD_W - GAIN_SHIFT;

    logic signed [PROD_W-1:0] prod;
    logic signed [SHR_W-1:0]  shifted;
    logic signed [OUT_W-1:0]  sat_value;
    logic signed [OUT_W-1:0]  unity_value;

    always_comb
    begin
        prod    = PROD_W'(pixel) * $signed({1'b0, gain});
        // arithmetic shift: rounds toward minus infinity
        shifted = prod[PROD_W-1:GAIN_SHIFT];
        if (shifted > SHR_W'(signed'({1'b0, {(OUT_W-1){1'b1}}})))
            sat_value = {1'b0, {(OUT_W-1){1'b1}}};
        else if (shifted < -(SHR_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) - SHR_W'(1))
            sat_value = {1'b1, {(OUT_W-1){1'b0}}};
        else
            sat_value = shifted[OUT_W-1:0];
        unity_value = {OUT_W'(pixel)} <<< OUT_FRAC;
        scaled      = normalize ? sat_value : unity_value;
    end

endmodule

FILE: hdl/fractional_step_image_decimator_unit.sv
// Top level of the fractional-step nearest-neighbor image decimator.
`timescale 1ns / 1ps

// Usage:
//   Input beats on s_* carry signed 16-bit pixels of one image in raster order.
//   Each pixel whose row and column match the floors of the running Q13.12
//   sample positions leaves on m_* as a signed Q24.8 value, times step squared
//   when normalize is set. m_tuser marks the last sample of an output row and
//   m_tlast the last sample of the frame. Other pixels are dropped.
//   Configuration: cfg_we with cfg_index/cfg_wdata writes a register; any
//   write, also to an unused index, restarts the frame. Write only while no
//   beat is in flight.
//   Throughput: one input beat per clock while s_tready is high. The sample
//   decision and counter update act at the input and register the pixel in
//   stage 1; the gain multiply feeds the output register (stage 2) on m_*.
//   The step-squared gain is formed once, when the step register is written.
//   Reset clears counters, registers to their defaults (1 x 1 image, step 2.0,
//   offset 0, gain off) and empties the pipeline.
//   When the receiver stalls, the output register holds its beat; the stage
//   behind it keeps taking dropped pixels and holds one more selected pixel,
//   then s_tready drops until m_tready.
module fractional_step_image_decimator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [fsid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fsid_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fsid_pkg::PIX_W-1:0]        s_tdata,   // [15:0] pixel_value
    // output sample stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fsid_pkg::OUT_W-1:0]        m_tdata,   // [31:0] scaled_value
    output logic                              m_tlast,   // last_in_frame
    output logic                              m_tuser    // [0] last_in_row
);
    import fsid_pkg::*;

    // configuration, kept in effective (clamped) form
    logic [DIMCFG_W-1:0] rows_reg;
    logic [DIMCFG_W-1:0] cols_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [OFS_W-1:0]    offset_reg;
    logic                normalize_reg;
    logic [GAIN_W-1:0]   gain_reg;

    // sampling grid state
    logic [DIM_BITS-1:0] row_cnt_reg, row_cnt_next;
    logic [DIM_BITS-1:0] col_cnt_reg, col_cnt_next;
    logic [POS_W-1:0]    row_pos_reg, row_pos_next;
    logic [POS_W-1:0]    col_pos_reg, col_pos_next;

    // stage 1: selected pixel and marks
    logic                    s1_valid_reg;
    logic signed [PIX_W-1:0] s1_pixel_reg;
    logic                    s1_lrow_reg;
    logic                    s1_lframe_reg;

    // stage 2: output register
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_value_reg;
    logic                    out_lrow_reg;
    logic                    out_lframe_reg;

    logic                    advance;
    logic                    in_fire;
    logic                    row_hit;
    logic                    col_hit;
    logic                    col_end;
    logic                    row_end;
    logic                    lrow;
    logic                    lframe;
    logic [POS_W:0]          col_sum;
    logic [POS_W:0]          row_sum;
    logic [POS_W-1:0]        offset_pos;
    logic [STEP_W-1:0]       wr_step;
    logic signed [OUT_W-1:0] scaled;

    // The output register frees when empty or taken; stage 1 moves with it.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    assign offset_pos = POS_W'(offset_reg);
    assign wr_step    = eff_step(cfg_wdata[STEP_W-1:0]);

    // Sample decision and end-of-row / end-of-frame marks.
    always_comb
    begin
        row_hit = row_pos_reg[POS_W-1:FRAC_BITS] == {1'b0, row_cnt_reg};
        col_hit = col_pos_reg[POS_W-1:FRAC_BITS] == {1'b0, col_cnt_reg};
        col_sum = {1'b0, col_pos_reg} + (POS_W+1)'(step_reg);
        row_sum = {1'b0, row_pos_reg} + (POS_W+1)'(step_reg);
        lrow    = col_sum[POS_W:FRAC_BITS] >= (POS_W+1-FRAC_BITS)'(cols_reg);
        lframe  = lrow && (row_sum[POS_W:FRAC_BITS] >= (POS_W+1-FRAC_BITS)'(rows_reg));
        col_end = ({1'b0, col_cnt_reg} + DIMCFG_W'(1)) >= cols_reg;
        row_end = ({1'b0, row_cnt_reg} + DIMCFG_W'(1)) >= rows_reg;
    end

    // Grid advance: counters wrap at the image edges, positions step on a hit.
    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_we)
        begin
            // restart the frame; on an offset write take the new offset
            row_cnt_next = '0;
            col_cnt_next = '0;
            if (cfg_index == REG_START_OFFSET)
            begin
                row_pos_next = POS_W'(cfg_wdata);
                col_pos_next = POS_W'(cfg_wdata);
            end
            else
            begin
                row_pos_next = offset_pos;
                col_pos_next = offset_pos;
            end
        end
        else if (in_fire)
        begin
            if (col_end)
            begin
                col_cnt_next = '0;
                col_pos_next = offset_pos;
                if (row_end)
                begin
                    row_cnt_next = '0;
                    row_pos_next = offset_pos;
                end
                else
                begin
                    if (row_hit)
                        row_pos_next = row_pos_reg + POS_W'(step_reg);
                    row_cnt_next = row_cnt_reg + DIM_BITS'(1);
                end
            end
            else
            begin
                if (col_hit)
                    col_pos_next = col_pos_reg + POS_W'(step_reg);
                col_cnt_next = col_cnt_reg + DIM_BITS'(1);
            end
        end
    end

    // Configuration registers; the gain is squared once at the step write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= DIM_RESET;
            cols_reg      <= DIM_RESET;
            step_reg      <= STEP_RESET;
            offset_reg    <= '0;
            normalize_reg <= 1'b0;
            gain_reg      <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_ROWS:   rows_reg      <= eff_dim(cfg_wdata[DIMCFG_W-1:0]);
                REG_IMAGE_COLS:   cols_reg      <= eff_dim(cfg_wdata[DIMCFG_W-1:0]);
                REG_SAMPLE_STEP:
                begin
                    step_reg <= wr_step;
                    gain_reg <= GAIN_W'(wr_step) * GAIN_W'(wr_step);
                end
                REG_START_OFFSET: offset_reg    <= cfg_wdata[OFS_W-1:0];
                REG_NORMALIZE:    normalize_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // Stage 1: hold the selected pixel until the output register frees.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= row_hit && col_hit;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg  <= s_tdata;
            s1_lrow_reg   <= lrow;
            s1_lframe_reg <= lframe;
        end
    end

    fsid_scale u_scale (
        .pixel     (s1_pixel_reg),
        .gain      (gain_reg),
        .normalize (normalize_reg),
        .scaled    (scaled)
    );

    // Stage 2: output register, held while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_value_reg  <= scaled;
            out_lrow_reg   <= s1_lrow_reg;
            out_lframe_reg <= s1_lframe_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_lrow_reg;
    assign m_tlast  = out_lframe_reg;

endmodule

FILE: verif/fractional_step_image_decimator_unit_tb.sv
// Self-checking testbench of the image decimator: raster pixels in, checked samples out.
`timescale 1ns / 1ps

module fractional_step_image_decimator_unit_tb;

    import fsid_pkg::*;

    localparam int     CLK_HALF        = 6;        // 12 ns period
    localparam int     RESET_CYCLES    = 12;
    localparam int     RANDOM_PIXELS   = 480;      // beats of the random part
    localparam int     FRAME_PIXEL_CAP = 160;      // most beats per random setting
    localparam int     EDGE_PIXELS     = 80;       // beats per dimension-limit run
    localparam int     IDLE_PCT        = 36;
    localparam int     SETTLE_CYCLES   = 6;        // pipeline is two stages deep, allow some slack
    localparam int     END_WAIT_LIMIT  = 4000;
    localparam longint RUN_LIMIT_NS    = 6_000_000;
    localparam longint SAT_HI          = 64'sd2147483647;
    localparam longint SAT_LO          = -64'sd2147483648;

    // Indexes past the register list: they restart the frame and change nothing else.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OUT_W-1:0] value;       // Q24.8
        logic             row_end;
        logic             frame_end;
    } decim_sample_t;

    // ------------------------------------------------------------------
    // Decimation predictor and sample scoreboard
    // ------------------------------------------------------------------
    class decim_scoreboard;
        logic [DIMCFG_W-1:0] rows_cfg;
        logic [DIMCFG_W-1:0] cols_cfg;
        logic [STEP_W-1:0]   step_cfg;
        logic [OFS_W-1:0]    offset_cfg;
        logic                norm_cfg;
        logic [DIM_BITS-1:0] row_cnt;
        logic [DIM_BITS-1:0] col_cnt;
        logic [POS_W-1:0]    row_pos;
        logic [POS_W-1:0]    col_pos;
        decim_sample_t       due_samples[$];
        int                  mismatches;

        function new();
            rows_cfg     = DIMCFG_W'(1);
            cols_cfg     = DIMCFG_W'(1);
            step_cfg     = STEP_W'(8192);
            offset_cfg   = '0;
            norm_cfg     = 1'b0;
            mismatches   = 0;
            restart();
        endfunction

        // Back to the top-left pixel, both grid positions at the offset.
        function void restart();
            row_cnt = '0;
            col_cnt = '0;
            row_pos = POS_W'(offset_cfg);
            col_pos = POS_W'(offset_cfg);
        endfunction

        function logic [DIMCFG_W-1:0] clamp_dim(input logic [DIMCFG_W-1:0] d);
            if (d == '0)
                return DIMCFG_W'(1);
            if (d > DIMCFG_W'(1 << DIM_BITS))
                return DIMCFG_W'(1 << DIM_BITS);
            return d;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_IMAGE_ROWS:   rows_cfg   = val[DIMCFG_W-1:0];
                REG_IMAGE_COLS:   cols_cfg   = val[DIMCFG_W-1:0];
                REG_SAMPLE_STEP:  step_cfg   = val[STEP_W-1:0];
                REG_START_OFFSET: offset_cfg = val[OFS_W-1:0];
                REG_NORMALIZE:    norm_cfg   = val[0];
                default: ;
            endcase
            restart();
        endfunction

        // Take one accepted pixel; queue the sample it yields, if any.
        function void decimate_pixel(input logic [PIX_W-1:0] raw);
            logic [DIMCFG_W-1:0] rows_eff;
            logic [DIMCFG_W-1:0] cols_eff;
            logic [STEP_W-1:0]   step_eff;
            logic                row_hit;
            logic                col_hit;
            logic [POS_W:0]      row_ahead;
            logic [POS_W:0]      col_ahead;
            longint              pix;
            longint              prod;
            longint              scaled;
            decim_sample_t       s;

            rows_eff = clamp_dim(rows_cfg);
            cols_eff = clamp_dim(cols_cfg);
            // no upsampling: anything under 1.0 runs at 1.0
            step_eff = (step_cfg < STEP_W'(1 << FRAC_BITS)) ?
                       STEP_W'(1 << FRAC_BITS) : step_cfg;
            pix      = longint'($signed(raw));
            row_hit  = (row_pos >> FRAC_BITS) == POS_W'(row_cnt);
            col_hit  = (col_pos >> FRAC_BITS) == POS_W'(col_cnt);

            if (row_hit && col_hit)
            begin
                if (norm_cfg)
                begin
                    // exact pixel * step^2, floor shift down to Q24.8, then clip
                    prod   = pix * longint'(step_eff) * longint'(step_eff);
                    scaled = prod >>> GAIN_SHIFT;
                    if (scaled > SAT_HI)
                        scaled = SAT_HI;
                    if (scaled < SAT_LO)
                        scaled = SAT_LO;
                end
                else
                begin
                    scaled = pix * 256;
                end
                // one bit wider than the positions: the look-ahead is not wrapped
                col_ahead   = col_pos + step_eff;
                row_ahead   = row_pos + step_eff;
                s.value     = scaled[OUT_W-1:0];
                s.row_end   = (col_ahead >> FRAC_BITS) >= cols_eff;
                s.frame_end = s.row_end && ((row_ahead >> FRAC_BITS) >= rows_eff);
                due_samples.push_back(s);
            end

            // Advance the raster counters; a position moves only after a hit.
            if (int'(col_cnt) + 1 >= int'(cols_eff))
            begin
                col_cnt = '0;
                col_pos = POS_W'(offset_cfg);
                if (int'(row_cnt) + 1 >= int'(rows_eff))
                begin
                    row_cnt = '0;
                    row_pos = POS_W'(offset_cfg);
                end
                else
                begin
                    if (row_hit)
                        row_pos = row_pos + step_eff;
                    row_cnt = row_cnt + 1'b1;
                end
            end
            else
            begin
                if (col_hit)
                    col_pos = col_pos + step_eff;
                col_cnt = col_cnt + 1'b1;
            end
        endfunction

        function void check_sample(input logic [OUT_W-1:0] value,
                                   input logic row_end, input logic frame_end);
            decim_sample_t want;
            if (due_samples.size() == 0)
            begin
                $display("%0t ns: unexpected sample, expected none, actual value=%h %s",
                         $time, value,
                         $sformatf("row_end=%b frame_end=%b", row_end, frame_end));
                mismatches++;
                return;
            end
            want = due_samples.pop_front();
            if (want.value !== value)
            begin
                $display("%0t ns: scaled_value expected %h actual %h",
                         $time, want.value, value);
                mismatches++;
            end
            if (want.row_end !== row_end)
            begin
                $display("%0t ns: last_in_row expected %b actual %b",
                         $time, want.row_end, row_end);
                mismatches++;
            end
            if (want.frame_end !== frame_end)
            begin
                $display("%0t ns: last_in_frame expected %b actual %b",
                         $time, want.frame_end, frame_end);
                mismatches++;
            end
        endfunction

        function int leftover();
            if (due_samples.size() != 0)
                $display("%0t ns: %0d expected samples never arrived, first expected value=%h",
                         $time, due_samples.size(), due_samples[0].value);
            return due_samples.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its drive signals, all known from time zero
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;    // [15:0] pixel_value
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;           // [31:0] scaled_value
    logic                  m_tlast;           // last_in_frame
    logic                  m_tuser;           // [0] last_in_row

    decim_scoreboard sb;
    int              tx_idle_pct = IDLE_PCT;
    int              rx_idle_pct = IDLE_PCT;

    logic [PIX_W-1:0] corner_pixels [8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                            16'h0001, 16'h5555, 16'hAAAA, 16'h8001};

    fractional_step_image_decimator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs or loses beats.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("fractional_step_image_decimator_unit: mismatch");
        $finish;
    end

    // Output side: check each beat taken at this edge, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_sample(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Drive tasks; each starts and ends just after a rising edge
    // ------------------------------------------------------------------

    // Write one register; cfg_we stays high so back-to-back writes need no gap.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Program a full image setting; optionally follow with a write past the register list.
    task automatic program_frame(input logic [DIMCFG_W-1:0] rows, input logic [DIMCFG_W-1:0] cols,
                                 input logic [STEP_W-1:0] step, input logic [OFS_W-1:0] ofs,
                                 input logic norm, input logic spare);
        cfg_write(REG_IMAGE_ROWS,   CFG_DATA_W'(rows));
        cfg_write(REG_IMAGE_COLS,   CFG_DATA_W'(cols));
        cfg_write(REG_SAMPLE_STEP,  CFG_DATA_W'(step));
        cfg_write(REG_START_OFFSET, CFG_DATA_W'(ofs));
        cfg_write(REG_NORMALIZE,    CFG_DATA_W'(norm));
        if (spare)
            cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one pixel after a random gap; return once the beat was taken.
    task automatic push_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.decimate_pixel(pix);
    endtask

    // Hold off input until every predicted sample has come back, then let the pipe empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.due_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0)
            return 16'h8000;
        if (sel == 1)
            return 16'h7FFF;
        return PIX_W'($urandom);
    endfunction

    task automatic send_pixels(input int count, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                settle();
            push_pixel(pick_pixel());
        end
    endtask

    // Mostly small images; zero now and then to hit the one-pixel clamp.
    function automatic int pick_dim();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return $urandom_range(40, 13);
        return $urandom_range(12, 1);
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return STEP_W'($urandom_range(4095));          // below 1.0
        if (sel == 1)
            return STEP_W'($urandom_range(65535, 32768));   // coarse grid
        return STEP_W'($urandom_range(14336, 4096));
    endfunction

    function automatic logic [OFS_W-1:0] pick_offset();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return OFS_W'($urandom);                        // usually past the image
        if (sel == 1)
            return '0;
        return OFS_W'($urandom_range(12288));
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int rows;
        int cols;
        int frame_len;
        int count;
        int phase;
        int random_sent;
        int waited;

        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset setting is a 1 x 1 image, so every pixel is a whole frame.
        push_pixel(16'h8000);
        push_pixel(16'h7FFF);
        settle();

        // Step under one runs at 1.0; normalize at 1.0 is unit gain: every pixel passes.
        program_frame(13'd2, 13'd4, 16'd0, 24'd0, 1'b1, 1'b0);
        foreach (corner_pixels[i])
            push_pixel(corner_pixels[i]);
        settle();

        // Largest step with gain on: one sample per frame, extremes of the product.
        program_frame(13'd2, 13'd2, 16'hFFFF, 24'd0, 1'b1, 1'b0);
        push_pixel(16'h7FFF);
        push_pixel(16'h0001);
        push_pixel(16'h0002);
        push_pixel(16'h0003);
        push_pixel(16'h8000);
        push_pixel(16'hFFFF);
        push_pixel(16'h0000);
        push_pixel(16'h1234);
        settle();

        // Offset past the image: nothing may come out.
        program_frame(13'd2, 13'd2, 16'd4096, 24'hFFFFFF, 1'b0, 1'b0);
        push_pixel(16'h4321);
        push_pixel(16'hBCDE);
        settle();

        // Half-pixel offset, step 1.5; a write past the list restarts mid-frame.
        program_frame(13'd2, 13'd3, 16'd6144, 24'd2048, 1'b0, 1'b0);
        push_pixel(16'h0101);
        push_pixel(16'h0202);
        settle();
        cfg_write(REG_SPARE_HI, 24'hFFFFFF);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_pixels(6, -1);
        settle();

        // Random images: whole frames with random content, some cut short.
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            // two phases run back to back with no gaps on either side
            tx_idle_pct = (phase == 1 || phase == 2) ? 0 : IDLE_PCT;
            rx_idle_pct = tx_idle_pct;
            rows = pick_dim();
            cols = pick_dim();
            program_frame(DIMCFG_W'(rows), DIMCFG_W'(cols), pick_step(), pick_offset(),
                          1'($urandom_range(1)), ($urandom_range(7) == 0));
            frame_len = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols);
            count     = frame_len * $urandom_range(3, 1);
            if ($urandom_range(3) == 0)
                count += $urandom_range(frame_len, 1);      // broken trailing frame
            if (count > FRAME_PIXEL_CAP)
                count = FRAME_PIXEL_CAP;
            if (count > RANDOM_PIXELS - random_sent)
                count = RANDOM_PIXELS - random_sent;
            // first phase: stop halfway until the output side has caught up
            send_pixels(count, (phase == 0) ? count / 2 : -1);
            settle();
            random_sent += count;
            phase++;
        end

        // Row at the 4096-column limit, coarsest grid, no gaps; only its first beats are sent.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_frame(13'd1, 13'd4096, 16'hFFFF, 24'd0, 1'b0, 1'b0);
        send_pixels(EDGE_PIXELS, -1);
        settle();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;

        // Row count above the limit clamps to 4096; one column, gain on.
        program_frame(13'h1FFF, 13'd1, 16'd8193, 24'd20580, 1'b1, 1'b0);
        send_pixels(EDGE_PIXELS, -1);

        // Wind down: let all outstanding samples arrive, bounded.
        s_tvalid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (sb.due_samples.size() != 0 && waited < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.leftover() == 0)
            $display("fractional_step_image_decimator_unit: match");
        else
            $display("fractional_step_image_decimator_unit: mismatch");
        $finish;
    end

endmodule
